/* design/fisr_pkg.sv */
// Shared constants and helpers for the fast inverse square root pipeline.
// Holds single-precision constants, unit latencies and leading-zero counters.
// No dependencies.
package fisr_pkg;

  localparam logic [31:0] MAGIC      = 32'h5f3759df;
  localparam logic [31:0] HALF_BITS  = 32'h3f000000;
  localparam logic [31:0] ONE_P5     = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN  = 32'h7fc00000;
  localparam int          MUL_LAT    = 4;
  localparam int          ADD_LAT    = 4;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* design/fisr_fmul.sv */
// Four-stage single-precision multiplier, round to nearest even, subnormals kept.
// Stages: unpack and multiply, leading-zero count, shift, round and pack.
// Depends on fisr_pkg.
module fisr_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] y
);
  import fisr_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               nan1_r, inf1_r, s1_r;
  logic [47:0]        m1_r;
  logic signed [10:0] e1_r;
  logic               nan2_r, inf2_r, s2_r, zero2_r, ovf2_r;
  logic [47:0]        m2_r;
  logic signed [10:0] sh2_r;
  logic [7:0]         ef2_r;
  logic               nan3_r, inf3_r, s3_r, zero3_r, ovf3_r;
  logic [47:0]        t3_r;
  logic [7:0]         ef3_r;
  logic [31:0]        y4_r;

  logic [7:0]  ea, eb, ea_eff, eb_eff;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic        nan1_nxt;
  logic signed [10:0] e1_nxt;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    a_nan  = (&ea) & (|a[22:0]);
    b_nan  = (&eb) & (|b[22:0]);
    a_inf  = (&ea) & ~(|a[22:0]);
    b_inf  = (&eb) & ~(|b[22:0]);
    a_zero = ~(|a[30:0]);
    b_zero = ~(|b[30:0]);
    ma     = {|ea, a[22:0]};
    mb     = {|eb, b[22:0]};
    ea_eff = (|ea) ? ea : 8'd1;
    eb_eff = (|eb) ? eb : 8'd1;
    nan1_nxt = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    e1_nxt = $signed({3'b000, ea_eff}) + $signed({3'b000, eb_eff}) - 11'sd127;
  end

  always_ff @(posedge clk) begin
    nan1_r <= nan1_nxt;
    inf1_r <= a_inf | b_inf;
    s1_r   <= a[31] ^ b[31];
    m1_r   <= ma * mb;
    e1_r   <= e1_nxt;
  end

  logic [5:0]         lz;
  logic signed [10:0] lz_s, ex;

  always_comb begin
    lz   = lzc48(m1_r);
    lz_s = $signed({5'b00000, lz});
    ex   = e1_r + 11'sd1 - lz_s;
  end

  always_ff @(posedge clk) begin
    nan2_r  <= nan1_r;
    inf2_r  <= inf1_r;
    s2_r    <= s1_r;
    zero2_r <= ~(|m1_r);
    m2_r    <= m1_r;
    sh2_r   <= (lz_s <= e1_r) ? lz_s : e1_r;
    ovf2_r  <= ex > 11'sd254;
    ef2_r   <= (ex < 11'sd1) ? 8'd0 : ex[7:0];
  end

  logic signed [10:0] neg_sh;
  logic [5:0]         rsh;
  logic [95:0]        wide;
  logic [47:0]        t3_nxt;

  always_comb begin
    neg_sh = -sh2_r;
    rsh    = (neg_sh > 11'sd63) ? 6'd63 : neg_sh[5:0];
    wide   = {m2_r, 48'd0} >> rsh;
    if (!sh2_r[10]) begin
      t3_nxt = m2_r << sh2_r[5:0];
    end else begin
      t3_nxt = wide[95:48] | {47'd0, |wide[47:0]};
    end
  end

  always_ff @(posedge clk) begin
    nan3_r  <= nan2_r;
    inf3_r  <= inf2_r;
    s3_r    <= s2_r;
    zero3_r <= zero2_r;
    ovf3_r  <= ovf2_r;
    ef3_r   <= ef2_r;
    t3_r    <= t3_nxt;
  end

  logic        inc;
  logic [30:0] packed_mag;
  logic [31:0] y4_nxt;

  always_comb begin
    inc        = t3_r[23] & ((|t3_r[22:0]) | t3_r[24]);
    packed_mag = {ef3_r, t3_r[46:24]} + {30'd0, inc};
    if (nan3_r) begin
      y4_nxt = CANON_NAN;
    end else if (inf3_r || (ovf3_r && !zero3_r)) begin
      y4_nxt = {s3_r, 8'hff, 23'd0};
    end else if (zero3_r) begin
      y4_nxt = {s3_r, 31'd0};
    end else begin
      y4_nxt = {s3_r, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    y4_r <= y4_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign y         = y4_r;

endmodule

/* design/fisr_fadd.sv */
// Four-stage single-precision adder, round to nearest even, subnormals kept.
// Stages: unpack and order, align and add, leading-zero count, shift and round.
// Depends on fisr_pkg.
module fisr_fadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] y
);
  import fisr_pkg::*;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        nan1_r, inf1_r, isg1_r, sub1_r, sg1_r, zs1_r;
  logic [7:0]  e1_r, d1_r;
  logic [23:0] mb1_r, ms1_r;
  logic        nan2_r, inf2_r, isg2_r, sg2_r, zs2_r;
  logic [7:0]  e2_r;
  logic [27:0] sum2_r;
  logic        nan3_r, inf3_r, isg3_r, sg3_r, zs3_r, zero3_r, ovf3_r;
  logic [27:0] sum3_r;
  logic [4:0]  sh3_r;
  logic [7:0]  ef3_r;
  logic [31:0] y4_r;

  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, small_op;
  logic [7:0]  eb_eff, es_eff;

  always_comb begin
    a_nan    = (&a[30:23]) & (|a[22:0]);
    b_nan    = (&b[30:23]) & (|b[22:0]);
    a_inf    = (&a[30:23]) & ~(|a[22:0]);
    b_inf    = (&b[30:23]) & ~(|b[22:0]);
    swap     = b[30:0] > a[30:0];
    big      = swap ? b : a;
    small_op = swap ? a : b;
    eb_eff   = (|big[30:23]) ? big[30:23] : 8'd1;
    es_eff   = (|small_op[30:23]) ? small_op[30:23] : 8'd1;
  end

  always_ff @(posedge clk) begin
    nan1_r <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
    inf1_r <= a_inf | b_inf;
    isg1_r <= a_inf ? a[31] : b[31];
    sub1_r <= a[31] ^ b[31];
    sg1_r  <= big[31];
    zs1_r  <= a[31] & b[31];
    e1_r   <= eb_eff;
    d1_r   <= eb_eff - es_eff;
    mb1_r  <= {|big[30:23], big[22:0]};
    ms1_r  <= {|small_op[30:23], small_op[22:0]};
  end

  logic [53:0] wide;
  logic [26:0] al;

  always_comb begin
    wide = {ms1_r, 3'b000, 27'd0} >> d1_r[4:0];
    if (d1_r >= 8'd27) begin
      al = {26'd0, |ms1_r};
    end else begin
      al = wide[53:27] | {26'd0, |wide[26:0]};
    end
  end

  always_ff @(posedge clk) begin
    nan2_r <= nan1_r;
    inf2_r <= inf1_r;
    isg2_r <= isg1_r;
    sg2_r  <= sg1_r;
    zs2_r  <= zs1_r;
    e2_r   <= e1_r;
    sum2_r <= sub1_r ? ({1'b0, mb1_r, 3'b000} - {1'b0, al})
                     : ({1'b0, mb1_r, 3'b000} + {1'b0, al});
  end

  logic [4:0]        lz;
  logic signed [9:0] lz_s, e_s, ex;

  always_comb begin
    lz   = lzc28(sum2_r);
    lz_s = $signed({5'b00000, lz});
    e_s  = $signed({2'b00, e2_r});
    ex   = e_s + 10'sd1 - lz_s;
  end

  always_ff @(posedge clk) begin
    nan3_r  <= nan2_r;
    inf3_r  <= inf2_r;
    isg3_r  <= isg2_r;
    sg3_r   <= sg2_r;
    zs3_r   <= zs2_r;
    zero3_r <= ~(|sum2_r);
    sum3_r  <= sum2_r;
    sh3_r   <= (lz_s <= e_s) ? lz : e2_r[4:0];
    ovf3_r  <= ex > 10'sd254;
    ef3_r   <= (ex < 10'sd1) ? 8'd0 : ex[7:0];
  end

  logic [27:0] t;
  logic        inc;
  logic [30:0] packed_mag;
  logic [31:0] y4_nxt;

  always_comb begin
    t          = sum3_r << sh3_r;
    inc        = t[3] & ((|t[2:0]) | t[4]);
    packed_mag = {ef3_r, t[26:4]} + {30'd0, inc};
    if (nan3_r) begin
      y4_nxt = CANON_NAN;
    end else if (inf3_r) begin
      y4_nxt = {isg3_r, 8'hff, 23'd0};
    end else if (zero3_r) begin
      y4_nxt = {zs3_r, 31'd0};
    end else if (ovf3_r) begin
      y4_nxt = {sg3_r, 8'hff, 23'd0};
    end else begin
      y4_nxt = {sg3_r, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    y4_r <= y4_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign y         = y4_r;

endmodule

/* design/fast_inverse_square_root.sv */
// Fast inverse square root: integer guess plus one Newton step in single precision.
// Top level; uses fisr_pkg, fisr_fmul and fisr_fadd.
//
// Usage:
//   Drive in_operand_bits and pulse start; a beat is taken at every edge where
//   start is high and busy is low. busy is always low, so one beat can enter
//   every cycle.
//   The result beat appears on out_rsqrt_bits with out_valid high for exactly
//   one cycle, once its input beat has gone through four multiplier passes
//   and one adder pass of 4 stages each, all fully pipelined.
//   Throughput is one beat per cycle; results leave in input order.
//   There is no back-pressure on the result side: the receiver must take each
//   beat in the cycle it is shown.
//   Synchronous reset (rst_n low) clears all valid bits; beats in flight are
//   dropped and no result beat follows until new input is taken.
//   A NaN result is always returned as 0x7FC00000.
module fast_inverse_square_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  output logic [31:0] out_rsqrt_bits
);
  import fisr_pkg::*;

  localparam int GDEPTH = 3 * MUL_LAT + ADD_LAT;

  logic [31:0] g_pipe_r [GDEPTH];
  logic        in_fire;
  logic        h_v, p_v, q_v, d_v, y_v;
  logic [31:0] h, p, q, d, yv;

  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  always_ff @(posedge clk) begin
    g_pipe_r[0] <= MAGIC - {1'b0, in_operand_bits[31:1]};
    for (int i = 1; i < GDEPTH; i++) begin
      g_pipe_r[i] <= g_pipe_r[i-1];
    end
  end

  fisr_fmul u_mul_h (
    .clk(clk), .rst_n(rst_n), .in_valid(in_fire),
    .a(in_operand_bits), .b(HALF_BITS), .out_valid(h_v), .y(h)
  );

  fisr_fmul u_mul_p (
    .clk(clk), .rst_n(rst_n), .in_valid(h_v),
    .a(h), .b(g_pipe_r[MUL_LAT-1]), .out_valid(p_v), .y(p)
  );

  fisr_fmul u_mul_q (
    .clk(clk), .rst_n(rst_n), .in_valid(p_v),
    .a(p), .b(g_pipe_r[2*MUL_LAT-1]), .out_valid(q_v), .y(q)
  );

  fisr_fadd u_sub_d (
    .clk(clk), .rst_n(rst_n), .in_valid(q_v),
    .a(ONE_P5), .b({~q[31], q[30:0]}), .out_valid(d_v), .y(d)
  );

  fisr_fmul u_mul_y (
    .clk(clk), .rst_n(rst_n), .in_valid(d_v),
    .a(g_pipe_r[GDEPTH-1]), .b(d), .out_valid(y_v), .y(yv)
  );

  assign out_valid      = y_v;
  assign out_rsqrt_bits = yv;

endmodule
